[rtl/core/pnsf_pkg.sv]
// Package for the pink noise shaping filter: widths, fixed-point coefficients,
// sequencer operation codes and the schedule decoder. No dependencies.
`timescale 1ns / 1ps

package pnsf_pkg;

  // Port and datapath widths
  localparam int SAMPLE_W = 16;   // white sample, Q1.15
  localparam int GAIN_W   = 16;   // amplitude gain, Q8.8
  localparam int OUT_W    = 32;   // pink sample, Q16.16
  localparam int STATE_W  = 40;   // filter state, Q16.24
  localparam int SUM_W    = STATE_W + 1;
  localparam int W_W      = 34;   // scaled white, Q.24
  localparam int PINK_W   = 44;   // pink accumulator, Q.24
  localparam int CHUNK_W  = 20;   // low partial-product chunk
  localparam int OPA_W    = PINK_W - CHUNK_W;
  localparam int COEF_W   = 25;
  localparam int PROD_W   = OPA_W + COEF_W;
  localparam int ACC_W    = 70;
  localparam int NUM_SEC  = 6;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 6;

  localparam int COEF_SHIFT = 24;
  localparam int NORM_SHIFT = 32;

  localparam logic [ACC_W-1:0] RND_COEF = ACC_W'(1) << (COEF_SHIFT - 1);
  localparam logic [ACC_W-1:0] RND_NORM = ACC_W'(1) << (NORM_SHIFT - 1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  // Schedule points of the sequencer
  localparam logic [CNT_W-1:0] CNT_SCALE     = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_SEC_LAST  = CNT_W'(4 * NUM_SEC);
  localparam logic [CNT_W-1:0] CNT_DELAY_LO  = CNT_W'(4 * NUM_SEC + 1);
  localparam logic [CNT_W-1:0] CNT_DIRECT_LO = CNT_W'(4 * NUM_SEC + 3);
  localparam logic [CNT_W-1:0] CNT_NORM_LO   = CNT_W'(4 * NUM_SEC + 8);
  localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(4 * NUM_SEC + 11);

  typedef logic signed [COEF_W-1:0] coef_t;

  // Q.24 coefficients
  localparam coef_t POLE_COEF [NUM_SEC] = '{
    25'sd16758090, 25'sd16665144, 25'sd16257122,
    25'sd14537458, 25'sd9227469,  -25'sd12777528
  };
  localparam coef_t FEED_COEF [NUM_SEC] = '{
    25'sd931436,  25'sd1259565, 25'sd2581208,
    25'sd5209084, 25'sd8941454, -25'sd283501
  };
  localparam coef_t DIRECT_COEF = 25'sd8995943;
  localparam coef_t DELAY_COEF  = 25'sd1944916;
  localparam coef_t NORM_COEF   = 25'sd1845494;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCALE,
    OP_POLE,
    OP_FEED,
    OP_DELAY,
    OP_DIRECT,
    OP_NORM
  } op_kind_e;

  typedef struct packed {
    logic             vld;
    op_kind_e         kind;
    logic [IDX_W-1:0] idx;
    logic             hi;
  } op_t;

  // Map a sequencer step to the partial product it issues.
  function automatic op_t op_decode(input logic [CNT_W-1:0] cnt);
    op_t              op;
    logic [CNT_W-1:0] k;
    op = '0;
    k  = cnt - CNT_W'(1);
    if (cnt == CNT_SCALE) begin
      op.vld  = 1'b1;
      op.kind = OP_SCALE;
    end else if (cnt <= CNT_SEC_LAST) begin
      op.vld  = 1'b1;
      op.kind = k[1] ? OP_FEED : OP_POLE;
      op.idx  = k[IDX_W+1:2];
      op.hi   = k[0];
    end else if (cnt == CNT_DELAY_LO || cnt == CNT_DELAY_LO + CNT_W'(1)) begin
      op.vld  = 1'b1;
      op.kind = OP_DELAY;
      op.hi   = (cnt != CNT_DELAY_LO);
    end else if (cnt == CNT_DIRECT_LO || cnt == CNT_DIRECT_LO + CNT_W'(1)) begin
      op.vld  = 1'b1;
      op.kind = OP_DIRECT;
      op.hi   = (cnt != CNT_DIRECT_LO);
    end else if (cnt == CNT_NORM_LO || cnt == CNT_NORM_LO + CNT_W'(1)) begin
      op.vld  = 1'b1;
      op.kind = OP_NORM;
      op.hi   = (cnt != CNT_NORM_LO);
    end
    return op;
  endfunction

  function automatic coef_t coef_of(input op_kind_e kind, input logic [IDX_W-1:0] idx);
    coef_t c;
    unique case (kind)
      OP_POLE:   c = POLE_COEF[idx];
      OP_FEED:   c = FEED_COEF[idx];
      OP_DELAY:  c = DELAY_COEF;
      OP_DIRECT: c = DIRECT_COEF;
      OP_NORM:   c = NORM_COEF;
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/pink_noise_shaping_filter_top.sv]
// Pink noise shaping filter: six one-pole sections plus delayed/direct white taps.
// A new sample is taken only once the previous one has run its whole schedule, which is
// set by the single shared 24x25 multiplier stepping through one scale product and 15
// products in two 20-bit chunks each; the schedule holds while a result waits.
// Reset: filter state, taps and output valid clear; amplitude gain returns to 1.0.
// Depends on pnsf_pkg.
`timescale 1ns / 1ps

module pink_noise_shaping_filter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: amplitude gain
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pnsf_pkg::GAIN_W-1:0]         cfg_data_i,
  // white input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pnsf_pkg::SAMPLE_W-1:0] white_sample_i,
  input  logic                                restart_i,
  // pink output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pnsf_pkg::OUT_W-1:0]   pink_sample_o,
  output logic                                clipped_o
);

  import pnsf_pkg::*;

  // ---------------------------------------------------------------------------
  // Control: sequencer counter walks the product schedule, at most one issue per step.
  // ---------------------------------------------------------------------------
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [GAIN_W-1:0] gain_q;
  logic             accept;
  logic             hold;
  logic             issue;
  op_t              op_s1;

  // Pipeline tags: t1 rides with the product, t2 with the rounded value,
  // t3 marks a section or direct-tap value bound for the pink accumulator.
  op_t              t1_q, t2_q;
  op_t              t1_d, t2_d;
  logic             t3_q, t3_d;

  logic             out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_data_q;
  logic             out_clip_q;

  assign accept      = in_valid_i && !busy_q;
  assign in_stall_o  = busy_q;
  assign cfg_ready_o = !busy_q;

  assign op_s1 = op_decode(cnt_q);
  // Hold before normalizing while the previous result is still pending, so
  // the output register is free when the new one lands.
  assign hold  = busy_q && (cnt_q == CNT_NORM_LO) && out_valid_q;
  assign issue = busy_q && !hold && op_s1.vld;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = CNT_SCALE;
    end else if (busy_q && !hold) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: operand select and shared multiply.
  // A 44-bit operand splits into a zero-extended low 20-bit chunk and a
  // signed upper chunk; the two partial products meet in the accumulator.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [W_W-1:0]      w_q;
  logic signed [STATE_W-1:0]  state_q [NUM_SEC];
  logic signed [STATE_W-1:0]  tap_q;
  logic signed [PINK_W-1:0]   pink_q;
  logic signed [STATE_W-1:0]  a_q;
  logic signed [STATE_W-1:0]  sec_rd;
  logic signed [PINK_W-1:0]   src;
  logic signed [OPA_W-1:0]    opa;
  coef_t                      opb;
  logic signed [PROD_W-1:0]   prod_d, prod_q;

  assign sec_rd = state_q[op_s1.idx];

  always_comb begin
    unique case (op_s1.kind) inside
      OP_POLE:                      src = PINK_W'(sec_rd);
      OP_FEED, OP_DELAY, OP_DIRECT: src = PINK_W'(w_q);
      OP_NORM:                      src = pink_q;
      default:                      src = PINK_W'(x_q);
    endcase
  end

  always_comb begin
    if (op_s1.kind == OP_SCALE) begin
      opa = OPA_W'(x_q);
      opb = $signed({{(COEF_W-GAIN_W){1'b0}}, gain_q});
    end else begin
      opa = op_s1.hi ? src[PINK_W-1:CHUNK_W]
                     : {{(OPA_W-CHUNK_W){1'b0}}, src[CHUNK_W-1:0]};
      opb = coef_of(op_s1.kind, op_s1.idx);
    end
  end

  assign prod_d = opa * opb;

  always_comb begin
    t1_d = '0;
    if (issue) begin
      t1_d = op_s1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: chunk accumulate and round-half-up shift.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  full;
  logic signed [ACC_W-1:0]  full_sh;
  logic signed [ACC_W-1:0]  rnd_add;
  logic signed [PINK_W-1:0] rnd_q;

  assign prod_ext = ACC_W'(prod_q);
  assign rnd_add  = (t1_q.kind == OP_NORM) ? $signed(RND_NORM) : $signed(RND_COEF);
  assign full     = acc_q + (prod_ext <<< CHUNK_W);
  assign full_sh  = (t1_q.kind == OP_NORM) ? (full >>> NORM_SHIFT) : (full >>> COEF_SHIFT);

  always_comb begin
    t2_d     = t1_q;
    t2_d.vld = t1_q.vld && t1_q.hi;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: section update with saturation, tap update, output saturation.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]   sec_sum;
  logic signed [STATE_W-1:0] sec_sat;
  logic signed [STATE_W-1:0] sec_q;
  logic [PINK_W-OUT_W:0]     y_top;
  logic                      y_ovf;

  assign sec_sum = SUM_W'(a_q) + SUM_W'($signed(rnd_q[STATE_W-1:0]));
  always_comb begin
    if (sec_sum[SUM_W-1] != sec_sum[SUM_W-2]) begin
      sec_sat = sec_sum[SUM_W-1] ? STATE_MIN : STATE_MAX;
    end else begin
      sec_sat = sec_sum[STATE_W-1:0];
    end
  end

  // Overflow when the bits above the output sign are not a pure sign copy.
  assign y_top = rnd_q[PINK_W-1:OUT_W-1];
  assign y_ovf = !((&y_top) || !(|y_top));

  assign t3_d = t2_q.vld && (t2_q.kind == OP_FEED || t2_q.kind == OP_DIRECT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (t2_q.vld && t2_q.kind == OP_NORM) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      gain_q      <= GAIN_RESET;
      t1_q        <= '0;
      t2_q        <= '0;
      t3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      t1_q        <= t1_d;
      t2_q        <= t2_d;
      t3_q        <= t3_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        gain_q <= cfg_data_i;
      end
    end
  end

  // Filter state: cleared by reset and by a restart transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEC; i++) begin
        state_q[i] <= '0;
      end
      tap_q <= '0;
    end else if (accept && restart_i) begin
      for (int i = 0; i < NUM_SEC; i++) begin
        state_q[i] <= '0;
      end
      tap_q <= '0;
    end else if (t2_q.vld) begin
      if (t2_q.kind == OP_FEED) begin
        state_q[t2_q.idx] <= sec_sat;
      end
      if (t2_q.kind == OP_DELAY) begin
        tap_q <= rnd_q[STATE_W-1:0];
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= white_sample_i;
      // Seed the pink sum with the previous delayed tap.
      pink_q <= restart_i ? '0 : PINK_W'(tap_q);
    end else if (t3_q) begin
      pink_q <= pink_q + PINK_W'(sec_q);
    end

    if (issue) begin
      prod_q <= prod_d;
    end

    if (t1_q.vld) begin
      if (t1_q.kind == OP_SCALE) begin
        w_q <= {prod_q[W_W-2:0], 1'b0};
      end else if (!t1_q.hi) begin
        acc_q <= prod_ext + rnd_add;
      end else begin
        rnd_q <= full_sh[PINK_W-1:0];
      end
    end

    if (t2_q.vld) begin
      unique case (t2_q.kind)
        OP_POLE:   a_q   <= rnd_q[STATE_W-1:0];
        OP_FEED:   sec_q <= sec_sat;
        OP_DIRECT: sec_q <= rnd_q[STATE_W-1:0];
        OP_NORM: begin
          out_clip_q <= y_ovf;
          if (y_ovf) begin
            out_data_q <= rnd_q[PINK_W-1] ? OUT_MIN : OUT_MAX;
          end else begin
            out_data_q <= rnd_q[OUT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pink_sample_o = out_data_q;
  assign clipped_o     = out_clip_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Never load a new result over one still waiting for transfer.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t2_q.vld && t2_q.kind == OP_NORM) |-> !out_valid_q)
    else $error("result loaded while output pending");

  // Pipeline drains before the block takes the next item.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (!t1_q.vld && !t2_q.vld && !t3_q))
    else $error("operation in flight while idle");

  // A high chunk always follows its low chunk in the next cycle.
  a_chunk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t1_q.vld && t1_q.hi) |-> ($past(t1_q.vld) && !$past(t1_q.hi)))
    else $error("high chunk without preceding low chunk");

  // A transfer starts the schedule from its first step.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && cnt_q == CNT_SCALE))
    else $error("sequencer did not start on transfer");

endmodule
